[src/sorted_list_insert_remove_macros.svh]
// assertion macros for the sorted list block and its checker
// no dependencies; included by the checker file
`ifndef SORTED_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_MACROS_SVH

// clocked assertion, held off while reset is low
`define SLI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define SLI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sli_pkg.sv]
// shared types and codes for the sorted list block
// no dependencies; imported by the cell, the top level and the checker
package sli_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic occ;
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

[src/sli_cell.sv]
// one slot of the sorted list: entry register, occupied bit, compare logic
// depends on sli_pkg
module sli_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sli_pkg::t_cell_cmd            i_cmd,
    input  logic signed [DATA_WIDTH-1:0]  i_value,
    input  sli_pkg::t_cell_flags          i_left,
    input  logic signed [DATA_WIDTH-1:0]  i_left_entry,
    input  logic                          i_right_occ,
    input  logic signed [DATA_WIDTH-1:0]  i_right_entry,
    output sli_pkg::t_cell_flags          o_flags,
    output logic signed [DATA_WIDTH-1:0]  o_entry
);
    import sli_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_entry, n_entry;
    logic                         r_occ, n_occ;
    logic                         w_lt;

    assign w_lt    = r_occ & (r_entry < i_value);
    assign o_flags = '{occ: r_occ, lt: w_lt, eq: r_occ & (r_entry == i_value)};
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        n_occ   = r_occ;
        if (i_cmd.insert && !w_lt) begin
            // at the insert point take the new value, past it shift up
            n_entry = i_left.lt ? i_value : i_left_entry;
            n_occ   = r_occ | i_left.occ;
        end else if (i_cmd.remove && !w_lt) begin
            // from the removed slot on, shift down
            n_entry = i_right_entry;
            n_occ   = i_right_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[src/sorted_list_insert_remove.sv]
// sorted list with insert and remove, built as a row of compare-and-shift cells
// depends on sli_pkg and sli_cell
//
// usage
//   input channel: i_in_valid / o_in_ready carry one word (i_action, i_value).
//     action insert places value ahead of the first stored entry that is not
//     smaller; action remove takes out the first entry equal to value.
//   output channel: o_out_valid / i_out_ready carry one word per input word:
//     o_status (done, not found, empty, full), o_removed_value (the value taken
//     out on a good remove, else 0) and o_entry_count after the operation.
//   result: registered, valid in the cycle after the input word is accepted.
//   throughput: one word per cycle while results are taken; every cell compares
//     the broadcast value and shifts with its neighbor in the same cycle, so the
//     compare plus the found reduction across the row is the only per-word work.
//   stall: results sit in one output register; the input is still accepted
//     while that register is being emptied, and is held off only while a
//     result waits and i_out_ready is low.
//   reset: synchronous, active low; the list comes up empty, the count is zero
//     and no result is pending. No clearing pass, entries are marked by the
//     per-cell occupied bits only.
//   an insert into a full list is rejected with status full, list unchanged.
module sorted_list_insert_remove #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic signed [sli_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [sli_pkg::VALUE_W-1:0]  o_removed_value,
    output logic [sli_pkg::COUNT_W-1:0]         o_entry_count
);
    import sli_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // broadcast value in stored width
    logic signed [DATA_WIDTH-1:0] w_value;
    logic                         w_accept;
    logic                         w_full, w_empty, w_found;
    t_cell_cmd                    w_cmd;
    t_status                      w_status;

    logic signed [DATA_WIDTH-1:0] w_entry [CAPACITY];
    t_cell_flags                  w_flags [CAPACITY];
    logic [CAPACITY-1:0]          w_match;

    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_out_valid;
    t_status                      r_status;
    logic signed [VALUE_W-1:0]    r_removed;
    logic [COUNT_W-1:0]           r_out_count;

    assign w_value    = DATA_WIDTH'(i_value);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    // entries below value form a prefix, so a match right after it is the first
    assign w_found = |w_match;

    // the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_flags                  w_left;
        logic signed [DATA_WIDTH-1:0] w_left_entry;
        logic                         w_right_occ;
        logic signed [DATA_WIDTH-1:0] w_right_entry;

        if (g == 0) begin : g_head
            assign w_left       = '{occ: 1'b1, lt: 1'b1, eq: 1'b0};
            assign w_left_entry = w_value;
        end else begin : g_mid
            assign w_left       = w_flags[g-1];
            assign w_left_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_occ   = 1'b0;
            assign w_right_entry = w_entry[g];
        end else begin : g_body
            assign w_right_occ   = w_flags[g+1].occ;
            assign w_right_entry = w_entry[g+1];
        end

        assign w_match[g] = w_flags[g].eq & w_left.lt;

        sli_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_value       (w_value),
            .i_left        (w_left),
            .i_left_entry  (w_left_entry),
            .i_right_occ   (w_right_occ),
            .i_right_entry (w_right_entry),
            .o_flags       (w_flags[g]),
            .o_entry       (w_entry[g])
        );
    end

    // operation decode and status
    always_comb begin
        w_cmd    = '{insert: 1'b0, remove: 1'b0};
        w_status = ST_DONE;
        n_count  = r_count;
        case (t_action'(i_action))
            ACT_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.insert = w_accept;
                    n_count      = r_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_found) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_cmd.remove = w_accept;
                    n_count      = r_count - 1'b1;
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word; the removed value equals the searched value
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_removed   <= w_cmd.remove ? VALUE_W'(w_value) : '0;
            r_out_count <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_entry_count   = r_out_count;

endmodule

[src/sli_checker.sv]
// port-level checks for the sorted list block, bound to its top level
// depends on sli_pkg and sorted_list_insert_remove_macros.svh
`include "sorted_list_insert_remove_macros.svh"

module sli_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [1:0]                          o_status,
    input logic signed [sli_pkg::VALUE_W-1:0]  o_removed_value,
    input logic [sli_pkg::COUNT_W-1:0]         o_entry_count
);
    import sli_pkg::*;

    // a pending result word holds until taken
    `SLI_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_removed_value) && $stable(o_entry_count), "result word changed while stalled")

    // only a good remove reports a value
    `SLI_ASSERT(a_removed_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_DONE) |-> (o_removed_value == '0), "removed value set on a failed operation")

    // full is reported only with the list at capacity
    `SLI_ASSERT(a_full_count, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL) |-> (o_entry_count == COUNT_W'(CAPACITY)), "full status with count below capacity")

    // empty is reported only with no entries
    `SLI_ASSERT(a_empty_count, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY) |-> (o_entry_count == '0), "empty status with entries stored")

    // no result word right after reset
    `SLI_ASSERT_ALWAYS(a_reset_idle, i_clk, !$past(i_rst_n) |-> (o_out_valid !== 1'b1), "result pending after reset")

endmodule

bind sorted_list_insert_remove sli_checker #(
    .CAPACITY (CAPACITY)
) u_sli_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_entry_count   (o_entry_count)
);
